// ===== rtl/core/paired_sample_statistics_defines.svh =====
// Assertion helpers shared by the RTL of the paired statistics block.
`ifndef PAIRED_SAMPLE_STATISTICS_DEFINES_SVH
`define PAIRED_SAMPLE_STATISTICS_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define PSS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define PSS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== rtl/core/pss_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pss_pkg;

    // Field and accumulator widths
    localparam int SMP_W   = 24;
    localparam int CNT_W   = 13;
    localparam int SX_W    = 37;
    localparam int SXX_W   = 59;
    localparam int SXY_W   = 60;
    localparam int PROD_W  = 2 * SMP_W;

    localparam int MEAN_W  = 24;
    localparam int PV_W    = 35;
    localparam int SV_W    = 36;
    localparam int STD_W   = 24;
    localparam int COV_W   = 37;
    localparam int CORR_W  = 17;
    localparam int STAT_W  = 2;
    localparam int R_W     = 16;

    // Arithmetic unit widths
    localparam int MUL_A_W = 60;
    localparam int MUL_B_W = 37;
    localparam int RES_W   = 97;
    localparam int OPND_W  = 88;
    localparam int SQ_IN_W = 72;
    localparam int SQ_RT_W = 36;
    localparam int SQ_RM_W = SQ_RT_W + 2;
    localparam int ITER_W  = 7;

    // Intermediate widths
    localparam int DX_W    = 72;
    localparam int CM_W    = 73;
    localparam int CW      = 75;
    localparam int CORR_SH = 15;

    // Snapshot queue
    localparam int QDEPTH  = 4;
    localparam int PTR_W   = 2;
    localparam int LVL_W   = 3;

    localparam logic [R_W-1:0] CORR_ONE = 16'h8000;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FEW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZVAR = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DROP = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic signed [SX_W-1:0]  sx;
        logic signed [SX_W-1:0]  sy;
        logic [SXX_W-1:0]        sxx;
        logic [SXX_W-1:0]        syy;
        logic signed [SXY_W-1:0] sxy;
        logic                    ovf;
    } snap_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_kind_t;

    typedef struct packed {
        logic     start;
        op_kind_t kind;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    // Back-end operation sequence
    typedef enum logic [4:0] {
        ST_NSXX, ST_SX2, ST_NSYY, ST_SY2, ST_NSXY, ST_SXSY, ST_NN, ST_NN1,
        ST_MX, ST_MY, ST_PV, ST_PSD, ST_SVX, ST_SSX, ST_SVY, ST_SSY,
        ST_CQ, ST_RDX, ST_RDY, ST_DEN, ST_R
    } step_t;

endpackage
`default_nettype wire

// ===== rtl/core/pss_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pss_front #(
    parameter int MAX_SAMPLES  = 4096,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [47:0]         s_tdata,
    input  wire                 s_tlast,
    input  wire                 q_room,
    output logic                push,
    output pss_pkg::snap_t      push_data
);
    import pss_pkg::*;

    localparam int SH = SMP_W - SAMPLE_WIDTH;

    logic                       accept;
    logic [SMP_W-1:0]           x_shl, y_shl;
    logic signed [SMP_W-1:0]    xs, ys;
    logic signed [PROD_W-1:0]   pxx, pyy, pxy;

    logic                       v1_reg, last1_reg;
    logic signed [SMP_W-1:0]    x1_reg, y1_reg;
    logic signed [PROD_W-1:0]   xx1_reg, yy1_reg, xy1_reg;

    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [SX_W-1:0]     sx_reg, sx_next, sy_reg, sy_next;
    logic [SXX_W-1:0]           sxx_reg, sxx_next, syy_reg, syy_next;
    logic signed [SXY_W-1:0]    sxy_reg, sxy_next;
    logic                       ovf_reg, ovf_next;
    logic                       keep;

    assign s_tready = q_room;
    assign accept   = s_tvalid && s_tready;

    // Sign extension from the configured sample width, then the products
    always_comb begin
        x_shl = s_tdata[23:0] << SH;
        y_shl = s_tdata[47:24] << SH;
        xs    = $signed(x_shl) >>> SH;
        ys    = $signed(y_shl) >>> SH;
        pxx   = xs * xs;
        pyy   = ys * ys;
        pxy   = xs * ys;
    end

    // Product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= accept;
        end
        if (accept) begin
            last1_reg <= s_tlast;
            x1_reg    <= xs;
            y1_reg    <= ys;
            xx1_reg   <= pxx;
            yy1_reg   <= pyy;
            xy1_reg   <= pxy;
        end
    end

    // Accumulate, or drop once capacity is reached
    always_comb begin
        keep      = cnt_reg < CNT_W'(MAX_SAMPLES);
        cnt_next  = cnt_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        sxx_next  = sxx_reg;
        syy_next  = syy_reg;
        sxy_next  = sxy_reg;
        ovf_next  = ovf_reg;
        if (keep) begin
            cnt_next = cnt_reg + 1'b1;
            sx_next  = sx_reg + {{(SX_W-SMP_W){x1_reg[SMP_W-1]}}, x1_reg};
            sy_next  = sy_reg + {{(SX_W-SMP_W){y1_reg[SMP_W-1]}}, y1_reg};
            sxx_next = sxx_reg + {{(SXX_W-PROD_W){1'b0}}, xx1_reg};
            syy_next = syy_reg + {{(SXX_W-PROD_W){1'b0}}, yy1_reg};
            sxy_next = sxy_reg + {{(SXY_W-PROD_W){xy1_reg[PROD_W-1]}}, xy1_reg};
        end else begin
            ovf_next = 1'b1;
        end
    end

    assign push = v1_reg && last1_reg;

    always_comb begin
        push_data.n   = cnt_next;
        push_data.sx  = sx_next;
        push_data.sy  = sy_next;
        push_data.sxx = sxx_next;
        push_data.syy = syy_next;
        push_data.sxy = sxy_next;
        push_data.ovf = ovf_next;
    end

    // Sums clear after the frame is handed over
    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (v1_reg) begin
            cnt_reg <= cnt_next;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sxx_reg <= sxx_next;
            syy_reg <= syy_next;
            sxy_reg <= sxy_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/pss_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "paired_sample_statistics_defines.svh"
module pss_fifo (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         push,
    input  pss_pkg::snap_t              push_data,
    input  wire                         pop,
    output pss_pkg::snap_t              pop_data,
    output logic                        empty,
    output logic [pss_pkg::LVL_W-1:0]   level
);
    import pss_pkg::*;

    snap_t              mem [QDEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [LVL_W-1:0]   level_reg;
    logic               full;

    assign full     = level_reg == LVL_W'(QDEPTH);
    assign empty    = level_reg == '0;
    assign level    = level_reg;
    assign pop_data = mem[rd_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    `PSS_ASSERT(a_fifo_no_overrun, !(push && full), "snapshot queue overrun")
    `PSS_ASSERT(a_fifo_no_underrun, !(pop && empty), "snapshot queue underrun")

endmodule
`default_nettype wire

// ===== rtl/core/pss_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "paired_sample_statistics_defines.svh"
module pss_alu (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  pss_pkg::alu_cmd_t           cmd,
    input  wire  [pss_pkg::OPND_W-1:0]  opa,
    input  wire  [pss_pkg::OPND_W-1:0]  opb,
    output logic [pss_pkg::RES_W-1:0]   res,
    output pss_pkg::alu_stat_t          stat
);
    import pss_pkg::*;

    typedef enum logic [3:0] {
        A_IDLE = 4'b0001,
        A_MUL  = 4'b0010,
        A_DIV  = 4'b0100,
        A_SQRT = 4'b1000
    } alu_state_t;

    alu_state_t             state_reg;
    logic [ITER_W-1:0]      cnt_reg;
    logic                   done_reg;
    op_kind_t               kind_reg;

    // shift-add multiplier
    logic [MUL_A_W-1:0]     ma_reg;
    logic [MUL_B_W-1:0]     mb_reg;
    logic [RES_W-1:0]       acc_reg, acc_next;
    // restoring divider
    logic [OPND_W-1:0]      num_reg, den_reg, drem_reg, drem_next;
    logic [OPND_W:0]        drem_s;
    logic                   dge;
    // digit-by-digit square root
    logic [SQ_IN_W-1:0]     rad_reg;
    logic [SQ_RM_W-1:0]     srem_reg, srem_next;
    logic [SQ_RT_W-1:0]     root_reg;
    logic [SQ_RM_W+1:0]     srem_s, trial;
    logic                   sge;
    logic                   last_iter;

    assign last_iter = cnt_reg == ITER_W'(1);

    // One step of each unit
    always_comb begin
        acc_next  = {acc_reg[RES_W-2:0], 1'b0}
                  + (mb_reg[MUL_B_W-1] ? {{(RES_W-MUL_A_W){1'b0}}, ma_reg} : '0);
        drem_s    = {drem_reg, num_reg[OPND_W-1]};
        dge       = drem_s >= {1'b0, den_reg};
        drem_next = dge ? OPND_W'(drem_s - {1'b0, den_reg}) : drem_s[OPND_W-1:0];
        srem_s    = {srem_reg, rad_reg[SQ_IN_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        sge       = srem_s >= trial;
        srem_next = sge ? SQ_RM_W'(srem_s - trial) : srem_s[SQ_RM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE: begin
                    if (cmd.start) begin
                        case (cmd.kind)
                            OP_MUL: begin
                                state_reg <= A_MUL;
                                cnt_reg   <= ITER_W'(MUL_B_W);
                            end
                            OP_DIV: begin
                                state_reg <= A_DIV;
                                cnt_reg   <= ITER_W'(OPND_W);
                            end
                            OP_SQRT: begin
                                state_reg <= A_SQRT;
                                cnt_reg   <= ITER_W'(SQ_RT_W);
                            end
                            default: begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                A_MUL, A_DIV, A_SQRT: begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_iter) begin
                        state_reg <= A_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (state_reg == A_IDLE && cmd.start) begin
            kind_reg <= cmd.kind;
            ma_reg   <= opa[MUL_A_W-1:0];
            mb_reg   <= opb[MUL_B_W-1:0];
            acc_reg  <= '0;
            num_reg  <= opa;
            den_reg  <= opb;
            drem_reg <= '0;
            rad_reg  <= opa[SQ_IN_W-1:0];
            srem_reg <= '0;
            root_reg <= '0;
        end else begin
            if (state_reg == A_MUL) begin
                acc_reg <= acc_next;
                mb_reg  <= {mb_reg[MUL_B_W-2:0], 1'b0};
            end
            if (state_reg == A_DIV) begin
                drem_reg <= drem_next;
                num_reg  <= {num_reg[OPND_W-2:0], dge};
            end
            if (state_reg == A_SQRT) begin
                srem_reg <= srem_next;
                rad_reg  <= {rad_reg[SQ_IN_W-3:0], 2'b00};
                root_reg <= {root_reg[SQ_RT_W-2:0], sge};
            end
        end
    end

    always_comb begin
        case (kind_reg)
            OP_MUL:  res = acc_reg;
            OP_DIV:  res = {{(RES_W-OPND_W){1'b0}}, num_reg};
            OP_SQRT: res = {{(RES_W-SQ_RT_W){1'b0}}, root_reg};
            default: res = '0;
        endcase
    end

    assign stat.busy = state_reg != A_IDLE;
    assign stat.done = done_reg;

    `PSS_ASSERT(a_alu_start_idle, cmd.start |-> state_reg == A_IDLE, "unit started while busy")
    `PSS_ASSERT(a_alu_done_pulse, done_reg |=> !done_reg, "done held longer than one cycle")

endmodule
`default_nettype wire

// ===== rtl/core/pss_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "paired_sample_statistics_defines.svh"
module pss_back #(
    parameter int FRAC_BITS = 12
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         q_empty,
    input  pss_pkg::snap_t              q_data,
    output logic                        q_pop,
    output pss_pkg::alu_cmd_t           cmd,
    output logic [pss_pkg::OPND_W-1:0]  opa,
    output logic [pss_pkg::OPND_W-1:0]  opb,
    input  wire  [pss_pkg::RES_W-1:0]   res,
    input  pss_pkg::alu_stat_t          stat,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [287:0]                m_tdata,
    output logic [1:0]                  m_tuser
);
    import pss_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_ISSUE = 4'b0010,
        B_WAIT  = 4'b0100,
        B_OUT   = 4'b1000
    } back_state_t;

    back_state_t            state_reg;
    step_t                  step_reg;
    snap_t                  snap_reg;

    logic [RES_W-1:0]       tmp_reg;
    logic [DX_W-1:0]        dx_reg, dy_reg, den_reg;
    logic [CM_W-1:0]        cm_reg;
    logic                   cneg_reg;
    logic [OPND_W-1:0]      pd_reg, sd_reg;
    logic [MEAN_W-1:0]      mx_reg, my_reg;
    logic [PV_W-1:0]        pv_reg;
    logic [SV_W-1:0]        svx_reg, svy_reg, cq_reg;
    logic [STD_W-1:0]       psd_reg, ssx_reg, ssy_reg;
    logic [SQ_RT_W-1:0]     rdx_reg, rdy_reg;
    logic [R_W-1:0]         r_reg;

    logic [SX_W-1:0]        ax, ay;
    logic [SXY_W-1:0]       axy;
    logic signed [CW-1:0]   t1, t2, cval;
    logic [CW-1:0]          cmag;
    logic [STD_W-1:0]       root_sat;
    logic [SV_W-1:0]        sv_sat;

    // Operand magnitudes
    always_comb begin
        ax  = snap_reg.sx[SX_W-1]   ? SX_W'(-snap_reg.sx)   : snap_reg.sx;
        ay  = snap_reg.sy[SX_W-1]   ? SX_W'(-snap_reg.sy)   : snap_reg.sy;
        axy = snap_reg.sxy[SXY_W-1] ? SXY_W'(-snap_reg.sxy) : snap_reg.sxy;
    end

    // Operation decode
    always_comb begin
        cmd.start = state_reg == B_ISSUE;
        cmd.kind  = OP_MUL;
        opa       = '0;
        opb       = '0;
        unique case (step_reg)
            ST_NSXX: begin
                opa = OPND_W'(snap_reg.sxx);
                opb = OPND_W'(snap_reg.n);
            end
            ST_SX2: begin
                opa = OPND_W'(ax);
                opb = OPND_W'(ax);
            end
            ST_NSYY: begin
                opa = OPND_W'(snap_reg.syy);
                opb = OPND_W'(snap_reg.n);
            end
            ST_SY2: begin
                opa = OPND_W'(ay);
                opb = OPND_W'(ay);
            end
            ST_NSXY: begin
                opa = OPND_W'(axy);
                opb = OPND_W'(snap_reg.n);
            end
            ST_SXSY: begin
                opa = OPND_W'(ax);
                opb = OPND_W'(ay);
            end
            ST_NN: begin
                opa = OPND_W'(snap_reg.n);
                opb = OPND_W'(snap_reg.n);
            end
            ST_NN1: begin
                opa = OPND_W'(snap_reg.n);
                opb = OPND_W'(CNT_W'(snap_reg.n - 1'b1));
            end
            ST_MX: begin
                cmd.kind = OP_DIV;
                opa      = OPND_W'(ax);
                opb      = OPND_W'(snap_reg.n);
            end
            ST_MY: begin
                cmd.kind = OP_DIV;
                opa      = OPND_W'(ay);
                opb      = OPND_W'(snap_reg.n);
            end
            ST_PV: begin
                cmd.kind = OP_DIV;
                opa      = OPND_W'(dx_reg);
                opb      = pd_reg;
            end
            ST_PSD: begin
                cmd.kind = OP_SQRT;
                opa      = OPND_W'(pv_reg) << FRAC_BITS;
            end
            ST_SVX: begin
                cmd.kind = OP_DIV;
                opa      = OPND_W'(dx_reg);
                opb      = sd_reg;
            end
            ST_SSX: begin
                cmd.kind = OP_SQRT;
                opa      = OPND_W'(svx_reg) << FRAC_BITS;
            end
            ST_SVY: begin
                cmd.kind = OP_DIV;
                opa      = OPND_W'(dy_reg);
                opb      = sd_reg;
            end
            ST_SSY: begin
                cmd.kind = OP_SQRT;
                opa      = OPND_W'(svy_reg) << FRAC_BITS;
            end
            ST_CQ: begin
                cmd.kind = OP_DIV;
                opa      = OPND_W'(cm_reg);
                opb      = sd_reg;
            end
            ST_RDX: begin
                cmd.kind = OP_SQRT;
                opa      = OPND_W'(dx_reg);
            end
            ST_RDY: begin
                cmd.kind = OP_SQRT;
                opa      = OPND_W'(dy_reg);
            end
            ST_DEN: begin
                opa = OPND_W'(rdx_reg);
                opb = OPND_W'(rdy_reg);
            end
            ST_R: begin
                cmd.kind = OP_DIV;
                opa      = OPND_W'(cm_reg) << CORR_SH;
                opb      = OPND_W'(den_reg);
            end
            default: begin
                cmd.kind = OP_MUL;
            end
        endcase
    end

    // Cross term and saturation helpers on the unit result
    always_comb begin
        t1       = snap_reg.sxy[SXY_W-1] ? -$signed(tmp_reg[CW-1:0]) : $signed(tmp_reg[CW-1:0]);
        t2       = (snap_reg.sx[SX_W-1] ^ snap_reg.sy[SX_W-1])
                 ? -$signed(res[CW-1:0]) : $signed(res[CW-1:0]);
        cval     = t1 - t2;
        cmag     = cval[CW-1] ? CW'(-cval) : cval;
        root_sat = (|res[RES_W-1:STD_W]) ? '1 : res[STD_W-1:0];
        sv_sat   = (|res[RES_W-1:SV_W]) ? '1 : res[SV_W-1:0];
    end

    assign q_pop = state_reg == B_IDLE && !q_empty;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            step_reg  <= ST_NSXX;
        end else begin
            unique case (state_reg)
                B_IDLE: begin
                    if (!q_empty) begin
                        state_reg <= B_ISSUE;
                        step_reg  <= ST_NSXX;
                    end
                end
                B_ISSUE: begin
                    state_reg <= B_WAIT;
                end
                B_WAIT: begin
                    if (stat.done) begin
                        if (step_reg == ST_R) begin
                            state_reg <= B_OUT;
                        end else begin
                            state_reg <= B_ISSUE;
                            step_reg  <= step_t'(step_reg + 5'd1);
                        end
                    end
                end
                B_OUT: begin
                    if (m_tready) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Result capture
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            snap_reg <= q_data;
        end
        if (state_reg == B_WAIT && stat.done) begin
            case (step_reg)
                ST_NSXX, ST_NSYY, ST_NSXY: tmp_reg <= res;
                ST_SX2:  dx_reg  <= tmp_reg[DX_W-1:0] - res[DX_W-1:0];
                ST_SY2:  dy_reg  <= tmp_reg[DX_W-1:0] - res[DX_W-1:0];
                ST_SXSY: begin
                    cneg_reg <= cval[CW-1];
                    cm_reg   <= cmag[CM_W-1:0];
                end
                ST_NN:   pd_reg  <= OPND_W'(res[OPND_W-1:0]) << FRAC_BITS;
                ST_NN1:  sd_reg  <= OPND_W'(res[OPND_W-1:0]) << FRAC_BITS;
                ST_MX:   mx_reg  <= res[MEAN_W-1:0];
                ST_MY:   my_reg  <= res[MEAN_W-1:0];
                ST_PV:   pv_reg  <= (|res[RES_W-1:PV_W]) ? '1 : res[PV_W-1:0];
                ST_PSD:  psd_reg <= root_sat;
                ST_SVX:  svx_reg <= sv_sat;
                ST_SSX:  ssx_reg <= root_sat;
                ST_SVY:  svy_reg <= sv_sat;
                ST_SSY:  ssy_reg <= root_sat;
                ST_CQ:   cq_reg  <= sv_sat;
                ST_RDX:  rdx_reg <= res[SQ_RT_W-1:0];
                ST_RDY:  rdy_reg <= res[SQ_RT_W-1:0];
                ST_DEN:  den_reg <= res[DX_W-1:0];
                ST_R: begin
                    r_reg <= ((|res[RES_W-1:R_W]) || res[R_W-1:0] > CORR_ONE)
                           ? CORR_ONE : res[R_W-1:0];
                end
                default: begin
                    tmp_reg <= tmp_reg;
                end
            endcase
        end
    end

    // Output assembly from the held results
    logic                       n0, few, zvar;
    logic [MEAN_W-1:0]          o_mx, o_my;
    logic [PV_W-1:0]            o_pv;
    logic [STD_W-1:0]           o_psd, o_ssx, o_ssy;
    logic [SV_W-1:0]            o_svx, o_svy;
    logic [COV_W-1:0]           o_cov;
    logic [CORR_W-1:0]          o_corr;
    logic [STAT_W-1:0]          o_stat;

    always_comb begin
        n0     = snap_reg.n == '0;
        few    = snap_reg.n < CNT_W'(2);
        zvar   = dx_reg == '0 || dy_reg == '0;
        o_mx   = n0 ? '0 : (snap_reg.sx[SX_W-1] ? MEAN_W'(-mx_reg) : mx_reg);
        o_my   = n0 ? '0 : (snap_reg.sy[SX_W-1] ? MEAN_W'(-my_reg) : my_reg);
        o_pv   = n0 ? '0 : pv_reg;
        o_psd  = n0 ? '0 : psd_reg;
        o_svx  = few ? '0 : svx_reg;
        o_ssx  = few ? '0 : ssx_reg;
        o_svy  = few ? '0 : svy_reg;
        o_ssy  = few ? '0 : ssy_reg;
        o_cov  = few ? '0 : (cneg_reg ? COV_W'(-{1'b0, cq_reg}) : {1'b0, cq_reg});
        o_corr = (few || zvar) ? '0
               : (cneg_reg ? CORR_W'(-{1'b0, r_reg}) : {1'b0, r_reg});
        if (snap_reg.ovf) begin
            o_stat = STAT_DROP;
        end else if (few) begin
            o_stat = STAT_FEW;
        end else if (zvar) begin
            o_stat = STAT_ZVAR;
        end else begin
            o_stat = STAT_OK;
        end
    end

    assign m_tvalid = state_reg == B_OUT;
    assign m_tdata  = {7'b0, o_corr, o_cov, o_ssy, o_svy, o_ssx, o_psd,
                       o_svx, o_pv, o_my, o_mx};
    assign m_tuser  = o_stat;

    `PSS_ASSERT(a_back_done_in_wait, stat.done |-> state_reg == B_WAIT, "unit done outside wait")

endmodule
`default_nettype wire

// ===== rtl/core/paired_sample_statistics.sv =====
// Paired sample statistics.
// Input channel s_*: one (x, y) pair per transaction, s_tlast marks the final
// pair of a dataset. Pairs are taken at one per cycle while the snapshot queue
// has room for two more frames; each pair goes through a product stage and
// into exact running sums.
// On the pair with s_tlast the sums are snapshotted into a four-deep queue and
// cleared. The back end pops a snapshot and walks it through 21 operations on
// one shared iterative unit: multiplies, divides and square roots, each
// issued and then awaited until the unit signals done. The result is then
// offered on m_*; the back end pops the next snapshot only after the
// current result has been accepted.
// Output channel m_*: one transaction per frame with all statistics in
// m_tdata and the status code in m_tuser. The result is held in registers
// until m_tready; while the receiver stalls, further pairs are still taken
// until the queue holds three snapshots, after which s_tready drops.
// Reset clears the sums, the queue and both sequencers; no transaction is
// pending after reset.
`timescale 1ns / 1ps
`default_nettype none
module paired_sample_statistics #(
    parameter int MAX_SAMPLES  = 4096,
    parameter int SAMPLE_WIDTH = 24,
    parameter int FRAC_BITS    = 12
) (
    input  wire             aclk,
    input  wire             aresetn,
    input  wire             s_tvalid,
    output logic            s_tready,
    input  wire  [47:0]     s_tdata,    // x_sample[23:0], y_sample[47:24]
    input  wire             s_tlast,
    output logic            m_tvalid,
    input  wire             m_tready,
    // mean_x, mean_y, pop_var_x, samp_var_x, pop_std_x, samp_std_x,
    // samp_var_y, samp_std_y, covariance_xy, correlation_xy, zero fill
    output logic [287:0]    m_tdata,
    output logic [1:0]      m_tuser     // status
);
    import pss_pkg::*;

    snap_t              push_data, pop_data;
    logic               push, pop, q_empty, q_room;
    logic [LVL_W-1:0]   q_level;
    alu_cmd_t           cmd;
    alu_stat_t          stat;
    logic [OPND_W-1:0]  opa, opb;
    logic [RES_W-1:0]   res;

    // Room for the frame in the product stage and one more
    assign q_room = q_level <= LVL_W'(QDEPTH - 2);

    pss_front #(
        .MAX_SAMPLES  (MAX_SAMPLES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_room    (q_room),
        .push      (push),
        .push_data (push_data)
    );

    pss_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .level     (q_level)
    );

    pss_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .opa     (opa),
        .opb     (opb),
        .res     (res),
        .stat    (stat)
    );

    pss_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (pop_data),
        .q_pop    (pop),
        .cmd      (cmd),
        .opa      (opa),
        .opb      (opb),
        .res      (res),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
